// File: design/plwl_pkg.sv
package plwl_pkg;

  localparam int TableDepthDef   = 32;
  localparam int FractionBitsDef = 8;
  localparam int PointW          = 16;
  localparam int ValueW          = 24;
  localparam int ValueMax        = 8388607;
  localparam int ValueMin        = -8388608;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } plwl_op_e;

  typedef enum logic [1:0] {
    StFound     = 2'd0,
    StUncovered = 2'd1,
    StStored    = 2'd2,
    StDropped   = 2'd3
  } plwl_status_e;

  typedef struct packed {
    logic              op;
    logic [PointW-1:0] point_x;
    logic [PointW-1:0] point_y;
    logic [ValueW-1:0] query_x;
  } plwl_in_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [1:0]        status;
  } plwl_out_t;

  typedef struct packed {
    logic [PointW-1:0] x;
    logic [PointW-1:0] y;
  } plwl_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         accept;
    logic         scan_start;
    logic         scan_rd;
    logic         scan_adv;
    logic         hit;
    logic         mul;
    logic         sum;
    logic         div_start;
    logic         div_take;
    logic         ins_start;
    logic         ins_rd;
    logic         ins_shift;
    logic         ins_write;
    logic         set_res;
    plwl_status_e res_code;
    logic         out_load;
  } plwl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic idx_zero;
    logic scan_end;
    logic match;
    logic interval;
    logic shift_needed;
    logic div_done;
  } plwl_sts_t;

endpackage

// File: design/plwl_div.sv
module plwl_div import plwl_pkg::*; #(
  parameter int DIVIDEND_W = 2 * PointW + 1 + FractionBitsDef,
  parameter int QUOT_W     = PointW + 1 + FractionBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DIVIDEND_W-1:0]            dividend_i,
  input  logic [DIVIDEND_W-QUOT_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [QUOT_W-1:0]                quot_o
);

  localparam int DivisorW = DIVIDEND_W - QUOT_W;
  localparam int CntW     = $clog2(QUOT_W + 1);

  logic [DivisorW-1:0] rem_q;
  logic [QUOT_W-1:0]   dq_q;
  logic [CntW-1:0]     cnt_q;
  logic                done_q;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                fits;

  // Restoring division, one quotient bit per cycle; the caller guarantees
  // the upper dividend part is below the divisor.
  assign trial = {rem_q, dq_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        cnt_q <= CntW'(QUOT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      done_q <= !start_i && (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DIVIDEND_W-1:QUOT_W];
      dq_q  <= dividend_i[QUOT_W-1:0];
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      dq_q  <= {dq_q[QUOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// File: design/plwl_dp.sv
module plwl_dp import plwl_pkg::*; #(
  parameter int TABLE_DEPTH   = TableDepthDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  plwl_in_t  in_data_i,
  input  plwl_cmd_t cmd_i,
  output plwl_sts_t sts_o,
  output plwl_out_t out_data_o
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int XaW  = PointW + FRACTION_BITS;
  localparam int CmpW = ((XaW > ValueW) ? XaW : ValueW) + 1;
  localparam int TW   = XaW;
  localparam int QW   = PointW + 1 + FRACTION_BITS;
  localparam int DivW = QW + PointW;
  localparam int NumW = DivW + 2;
  localparam int P1W  = 2 * PointW + 1;
  localparam int P2W  = PointW + 1 + TW + 1;
  localparam int SW   = QW + 1;
  localparam int SatW = ((SW > ValueW) ? SW : ValueW) + 1;

  localparam logic signed [SatW-1:0] SatMax = SatW'(ValueMax);
  localparam logic signed [SatW-1:0] SatMin = SatW'(ValueMin);

  plwl_in_t    item_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] idx_m1;
  plwl_entry_t mem [TABLE_DEPTH];
  plwl_entry_t rd_q;
  plwl_entry_t prev_q;
  logic        prev_vld_q;

  logic            mem_we;
  logic            mem_re;
  logic [IdxW-1:0] mem_wa;
  logic [IdxW-1:0] mem_ra;
  plwl_entry_t     mem_wd;

  logic signed [CmpW-1:0] q_ext;
  logic signed [CmpW-1:0] xa_cur;
  logic signed [CmpW-1:0] xa_prev;
  logic signed [CmpW-1:0] t_full;
  logic [PointW:0]        x_diff;
  logic [PointW:0]        y_diff;

  logic [PointW-1:0]        d_q;
  logic signed [PointW:0]   dy_q;
  logic [TW-1:0]            t_q;
  logic signed [PointW-1:0] y1_q;
  logic signed [P1W-1:0]    p1_q;
  logic signed [P2W-1:0]    p2_q;
  logic signed [NumW-1:0]   p1_ext;
  logic signed [NumW-1:0]   p2_ext;
  logic signed [NumW-1:0]   num;
  logic [NumW-1:0]          mag_full;
  logic                     neg_q;
  logic [DivW-1:0]          mag_q;

  logic                   div_done;
  logic [QW-1:0]          quot;
  logic [SW-1:0]          quot_u;
  logic signed [SW-1:0]   quot_s;
  logic signed [SW-1:0]   y_one;
  logic signed [SW-1:0]   sat_in;
  logic signed [SatW-1:0] sat_ext;
  logic [ValueW-1:0]      sat_val;

  logic [ValueW-1:0] res_value_q;
  logic [1:0]        res_status_q;
  plwl_out_t         out_q;

  // Table memory: one write and one registered read per cycle
  assign idx_m1 = idx_q - CntW'(1);
  assign mem_we = cmd_i.ins_shift || cmd_i.ins_write;
  assign mem_wa = idx_q[IdxW-1:0];
  assign mem_wd = cmd_i.ins_write ? plwl_entry_t'({item_q.point_x, item_q.point_y}) : rd_q;
  assign mem_re = cmd_i.scan_rd || cmd_i.ins_rd;
  assign mem_ra = cmd_i.ins_rd ? idx_m1[IdxW-1:0] : idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Compare in the query's fixed-point format
  assign q_ext   = $signed({{(CmpW-ValueW){item_q.query_x[ValueW-1]}}, item_q.query_x});
  assign xa_cur  = $signed({{(CmpW-PointW){rd_q.x[PointW-1]}}, rd_q.x}) <<< FRACTION_BITS;
  assign xa_prev = $signed({{(CmpW-PointW){prev_q.x[PointW-1]}}, prev_q.x}) <<< FRACTION_BITS;
  assign t_full  = q_ext - xa_prev;
  assign x_diff  = {rd_q.x[PointW-1], rd_q.x} - {prev_q.x[PointW-1], prev_q.x};
  assign y_diff  = {rd_q.y[PointW-1], rd_q.y} - {prev_q.y[PointW-1], prev_q.y};

  assign sts_o.full         = count_q == CntW'(TABLE_DEPTH);
  assign sts_o.idx_zero     = idx_q == '0;
  assign sts_o.scan_end     = idx_q == count_q;
  assign sts_o.match        = xa_cur == q_ext;
  assign sts_o.interval     = prev_vld_q && (xa_prev < q_ext) && (q_ext < xa_cur);
  assign sts_o.shift_needed = $signed(rd_q.x) > $signed(item_q.point_x);
  assign sts_o.div_done     = div_done;

  // Numerator y1*one*d + dy*(q-xa); magnitude goes to the divider
  assign p1_ext   = $signed({{(NumW-P1W){p1_q[P1W-1]}}, p1_q});
  assign p2_ext   = $signed({{(NumW-P2W){p2_q[P2W-1]}}, p2_q});
  assign num      = (p1_ext <<< FRACTION_BITS) + p2_ext;
  assign mag_full = num[NumW-1] ? NumW'(-num) : NumW'(num);

  plwl_div #(
    .DIVIDEND_W (DivW),
    .QUOT_W     (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Sign, then clamp to the value range
  assign quot_u  = {1'b0, quot};
  assign quot_s  = neg_q ? $signed(-quot_u) : $signed(quot_u);
  assign y_one   = $signed({{(SW-PointW){rd_q.y[PointW-1]}}, rd_q.y}) <<< FRACTION_BITS;
  assign sat_in  = cmd_i.div_take ? quot_s : y_one;
  assign sat_ext = $signed({{(SatW-SW){sat_in[SW-1]}}, sat_in});

  always_comb begin
    priority if (sat_ext > SatMax) begin
      sat_val = SatMax[ValueW-1:0];
    end else if (sat_ext < SatMin) begin
      sat_val = SatMin[ValueW-1:0];
    end else begin
      sat_val = sat_ext[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      prev_vld_q <= 1'b0;
    end else begin
      priority if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.ins_start) begin
        idx_q <= count_q;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + CntW'(1);
      end else if (cmd_i.ins_shift) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.ins_write) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.scan_start) begin
        prev_vld_q <= 1'b0;
      end else if (cmd_i.scan_adv) begin
        prev_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_adv) begin
      prev_q <= rd_q;
    end
    if (cmd_i.hit) begin
      d_q  <= x_diff[PointW-1:0];
      dy_q <= $signed(y_diff);
      t_q  <= t_full[TW-1:0];
      y1_q <= $signed(prev_q.y);
    end
    if (cmd_i.mul) begin
      p1_q <= y1_q * $signed({1'b0, d_q});
      p2_q <= dy_q * $signed({1'b0, t_q});
    end
    if (cmd_i.sum) begin
      neg_q <= num[NumW-1];
      mag_q <= mag_full[DivW-1:0];
    end
    priority if (cmd_i.set_res) begin
      res_value_q  <= '0;
      res_status_q <= cmd_i.res_code;
    end else if (cmd_i.div_take || (cmd_i.hit && sts_o.match)) begin
      res_value_q  <= sat_val;
      res_status_q <= StFound;
    end
    if (cmd_i.out_load) begin
      out_q.value  <= res_value_q;
      out_q.status <= res_status_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: design/plwl_ctrl.sv
module plwl_ctrl import plwl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output plwl_cmd_t cmd_o,
  input  plwl_sts_t sts_i
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_SUM     = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_DIVW    = 4'd5;
  localparam logic [3:0] S_INS_RD  = 4'd6;
  localparam logic [3:0] S_INS_CMP = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       chk_q, chk_d;
  logic       out_valid_q, out_valid_d;
  plwl_cmd_t  cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    chk_d   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          if (in_op_i == OpQuery) begin
            cmd.scan_start = 1'b1;
            state_d        = S_SCAN;
          end else if (sts_i.full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = StDropped;
            state_d      = S_DONE;
          end else begin
            cmd.ins_start = 1'b1;
            state_d       = S_INS_RD;
          end
        end
      end
      S_SCAN: begin
        // Check the entry read last cycle while reading the next one
        if (chk_q && (sts_i.match || sts_i.interval)) begin
          cmd.hit = 1'b1;
          state_d = sts_i.match ? S_DONE : S_MUL;
        end else begin
          cmd.scan_adv = chk_q;
          if (!sts_i.scan_end) begin
            cmd.scan_rd = 1'b1;
            chk_d       = 1'b1;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = StUncovered;
            state_d      = S_DONE;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd.div_take = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_INS_RD: begin
        if (sts_i.idx_zero) begin
          cmd.ins_write = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_code  = StStored;
          state_d       = S_DONE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_d    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // Move larger entries up one slot until the insert point is found
        if (sts_i.shift_needed) begin
          cmd.ins_shift = 1'b1;
          state_d       = S_INS_RD;
        end else begin
          cmd.ins_write = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_code  = StStored;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: design/piecewise_linear_lookup.sv
// Piecewise-linear lookup table.
// Input channel (in_valid_i / in_ready_o / in_data_i): each transfer is either
// a load, which inserts an (x, y) breakpoint into a table kept sorted by
// ascending x, or a query, which returns y for a signed fixed-point x by
// exact match or linear interpolation between neighboring breakpoints.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transfer per
// input transfer, in order, carrying the value and a status code.
// Timing: one item is worked on at a time. A query scans the table one entry
// per cycle through the memory read port; to interpolate, it then runs a
// multiply step, a sum step and a bit-serial divider. A load moves every
// larger entry up one slot, reading it and then writing it back, before it
// writes the new point into the slot left free.
// Reset clears the entry count, not the table contents; no clearing pass over the memory.
// The output register lets the next item be taken while a result waits;
// if the receiver stalls, the following result holds until the register
// frees and the input stays not ready meanwhile.
module piecewise_linear_lookup import plwl_pkg::*; #(
  parameter int TABLE_DEPTH   = TableDepthDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  plwl_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output plwl_out_t out_data_o
);

  plwl_cmd_t cmd;
  plwl_sts_t sts;

  // Sequencer: scan, insert, arithmetic steps and output hand-off
  plwl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Table memory, comparators, multipliers, divider and result registers
  plwl_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // Drop ready for the cycle after a transfer: the item is now in progress
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // Never write a new breakpoint into a full table
  a_insert_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_write |-> !sts.full)
    else $error("breakpoint written into a full table");

  // Never read past the stored entries during a scan
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> !sts.scan_end)
    else $error("scan read beyond the entry count");

  // Load results carry a zero value
  a_load_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StStored || out_data_o.status == StDropped))
      |-> (out_data_o.value == '0))
    else $error("load result with nonzero value");

endmodule

// File: dv/piecewise_linear_lookup_tb.sv
module piecewise_linear_lookup_tb import plwl_pkg::*; ();

  localparam int     DEPTH        = TableDepthDef;
  localparam int     FRAC         = FractionBitsDef;
  localparam longint ONE          = longint'(1) << FRAC;
  localparam int     PERIOD       = 10;
  localparam int     RANDOM_ITEMS = 1430;
  localparam int     SETTLE       = 100;
  localparam int     TIMEOUT      = 20_000_000;

  // Breakpoint table tracker: mirrors the sorted table, turns each accepted
  // transfer into the result it must produce and holds those in order.
  class table_scoreboard;
    logic signed [PointW-1:0] bp_x [DEPTH];
    logic signed [PointW-1:0] bp_y [DEPTH];
    int        n_points;
    plwl_out_t pending_results [$];
    int        n_errors, n_checked, n_stored, n_dropped, n_found, n_uncovered;

    function logic [ValueW-1:0] saturate(longint v);
      if (v > ValueMax) v = ValueMax;
      if (v < ValueMin) v = ValueMin;
      return v[ValueW-1:0];
    endfunction

    function plwl_out_t lookup_result(plwl_in_t item);
      plwl_out_t res;
      int        pos;
      longint    q, xa, xb, span, y1, dy, acc;
      res.value = '0;
      if (item.op == OpLoad) begin
        if (n_points >= DEPTH) begin
          res.status = StDropped;
          n_dropped++;
        end else begin
          // Insert after every entry with x not above the new one.
          pos = 0;
          while (pos < n_points && bp_x[pos] <= $signed(item.point_x)) pos++;
          for (int k = n_points; k > pos; k--) begin
            bp_x[k] = bp_x[k-1];
            bp_y[k] = bp_y[k-1];
          end
          bp_x[pos] = item.point_x;
          bp_y[pos] = item.point_y;
          n_points++;
          res.status = StStored;
          n_stored++;
        end
      end else begin
        q = longint'($signed(item.query_x));
        res.status = StUncovered;
        for (int i = 0; i < n_points; i++) begin
          xa = longint'(bp_x[i]) * ONE;
          if (xa == q) begin
            res.value  = saturate(longint'(bp_y[i]) * ONE);
            res.status = StFound;
            break;
          end
          if (i + 1 < n_points) begin
            xb = longint'(bp_x[i+1]) * ONE;
            if (xa < q && q < xb) begin
              span = longint'(bp_x[i+1]) - longint'(bp_x[i]);
              y1   = longint'(bp_y[i]);
              dy   = longint'(bp_y[i+1]) - y1;
              acc  = y1 * ONE * span + dy * (q - xa);
              // Division truncates toward zero, as the block does.
              res.value  = saturate(acc / span);
              res.status = StFound;
              break;
            end
          end
        end
        if (res.status == StFound) n_found++;
        else n_uncovered++;
      end
      return res;
    endfunction

    function void note_input(plwl_in_t item);
      pending_results.insert(pending_results.size(), lookup_result(item));
    endfunction

    function void check_result(plwl_out_t got);
      plwl_out_t want;
      if (pending_results.size() == 0) begin
        n_errors++;
        $error("unexpected result: value %0d status %0d", $signed(got.value), got.status);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.value !== want.value) begin
        n_errors++;
        $error("value: expected %0d, actual %0d", $signed(want.value), $signed(got.value));
      end
      if (got.status !== want.status) begin
        n_errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  plwl_in_t  in_data_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  plwl_out_t out_data_o;

  table_scoreboard sb = new();

  piecewise_linear_lookup u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Unused fields of each item carry random junk; the block must ignore it.
  function automatic plwl_in_t load_point(int x, int y);
    plwl_in_t item;
    item.op      = OpLoad;
    item.point_x = x[PointW-1:0];
    item.point_y = y[PointW-1:0];
    item.query_x = ValueW'($urandom);
    return item;
  endfunction

  function automatic plwl_in_t query_at(longint q);
    plwl_in_t item;
    item.op      = OpQuery;
    item.point_x = PointW'($urandom);
    item.point_y = PointW'($urandom);
    item.query_x = q[ValueW-1:0];
    return item;
  endfunction

  // Bias loads toward duplicates and tightly packed x so that narrow and
  // zero-width neighbors show up next to full-range points.
  function automatic plwl_in_t make_load();
    int unsigned r;
    int          x, y;
    r = $urandom_range(0, 99);
    if (r < 20 && sb.n_points > 0) x = sb.bp_x[$urandom_range(0, sb.n_points - 1)];
    else if (r < 50) x = int'($urandom_range(0, 16)) - 8;
    else x = $urandom;
    if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 1) ? -32768 : 32767;
    else y = $urandom;
    return load_point(x, y);
  endfunction

  // Aim most queries at the table: exact breakpoints, inside an interval
  // (edges excluded), or just past either end; the rest span the full range.
  function automatic plwl_in_t make_query();
    plwl_in_t    item;
    int unsigned pick, k;
    longint      q, lo, hi;
    item = query_at(longint'($urandom));
    if (sb.n_points == 0) return item;
    q    = longint'($signed(item.query_x));
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, sb.n_points - 1);
    lo   = longint'(sb.bp_x[k]) * ONE;
    if (pick < 40) begin
      q = lo;
    end else if (pick < 75 && k + 1 < sb.n_points && sb.bp_x[k+1] != sb.bp_x[k]) begin
      hi = longint'(sb.bp_x[k+1]) * ONE;
      case ($urandom_range(0, 3))
        0: q = lo + 1;
        1: q = hi - 1;
        default: q = lo + longint'($urandom_range(1, hi - lo - 1));
      endcase
    end else if (pick < 88) begin
      if ($urandom_range(0, 1)) q = longint'(sb.bp_x[0]) * ONE - longint'($urandom_range(1, 600));
      else q = longint'(sb.bp_x[sb.n_points-1]) * ONE + longint'($urandom_range(1, 600));
    end
    if (q >= ValueMin && q <= ValueMax) item.query_x = q[ValueW-1:0];
    return item;
  endfunction

  // Raise valid with the payload and hold both until the transfer happens,
  // then record it. Valid stays high so a following item can go back to back.
  task automatic send_item(input plwl_in_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every expected result has been checked.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Result side: check each transfer against the oldest expectation and
  // stall at random, with some stretches where ready stays high.
  initial begin : receive_results
    int stall;
    int cycle;
    stall = 0;
    cycle = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = ((cycle / 400) % 4 == 1) ? 0 : pick_gap();
      end
    end
  end

  initial begin : stimulus
    plwl_in_t directed [$];
    bit       sender_quiet;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty and one-entry table, extremes of x and y, duplicate x,
    // exact hits at both ends, just-outside queries, interval edges and
    // truncation toward zero of a negative interpolated value.
    directed = '{
      query_at(0), query_at(ValueMin),
      load_point(5, 100),
      query_at(5 * ONE), query_at(5 * ONE + 1), query_at(5 * ONE - 1),
      load_point(-32768, -32768), load_point(32767, 32767), load_point(5, -7),
      query_at(5 * ONE), query_at(ValueMin), query_at(ValueMax),
      query_at(32767 * ONE), query_at(ValueMin + 1), query_at(32767 * ONE - 1),
      load_point(10, -1),
      query_at(5 * ONE + 1), query_at(10 * ONE - 1), query_at(7 * ONE + 128),
      load_point(-1, 0), query_at(-128)
    };
    foreach (directed[i]) begin
      send_item(directed[i]);
      idle_sender(pick_gap());
    end
    drain_results();

    // Random: queries dominate; loads trickle in so that the table is
    // queried at every fill level, then fills up and further loads drop.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_quiet = ((i / 150) % 4) == 2;
      if ($urandom_range(0, 99) < 6 || (i > 900 && sb.n_points < DEPTH))
        send_item(make_load());
      else
        send_item(make_query());
      if ($urandom_range(0, 199) == 0) drain_results();
      else idle_sender(sender_quiet ? 0 : pick_gap());
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);

    $display("Checked %0d results: %0d loads stored, %0d dropped on a full table,",
             sb.n_checked, sb.n_stored, sb.n_dropped);
    $display("%0d queries answered by match or interpolation, %0d not covered.",
             sb.n_found, sb.n_uncovered);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
